@@ rtl/core/nma_pkg.sv @@
package nma_pkg;

    localparam int ACT_TABLE_DEPTH = 256;
    localparam int DATA_W          = 32;
    localparam int ACC_W           = 48;
    localparam int Q_FRAC_W        = 16;
    localparam int TAB_FRAC_W      = 20;
    localparam int TAB_W           = 18;
    localparam int TAB_AW          = $clog2(ACT_TABLE_DEPTH + 1);
    localparam int CFG_AW          = 2;
    localparam int SLOPE_W         = 16;

    localparam logic [63:0] Q32_ONE       = 64'd1 << 32;
    localparam logic [63:0] INV_E_Q32     = 64'd1580030169;
    localparam logic [63:0] ACT_DEPTH_U64 = 64'(ACT_TABLE_DEPTH);
    localparam logic [DATA_W:0] U_OFFSET  = (DATA_W + 1)'(8 << Q_FRAC_W);

    typedef enum logic [CFG_AW-1:0] {
        CFG_BIAS       = 2'd0,
        CFG_ACT_SEL    = 2'd1,
        CFG_LEAK_SLOPE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_SIGMOID = 2'd0,
        ACT_TANH    = 2'd1,
        ACT_RELU    = 2'd2,
        ACT_LEAKY   = 2'd3
    } act_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_BIAS,
        ST_ACT,
        ST_LEAKY,
        ST_EDGE,
        ST_TIDX,
        ST_TRD1,
        ST_TRD2,
        ST_TFIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] weight;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] activation_out;
        logic                     overflow;
    } out_item_t;

    typedef struct packed {
        logic              rd_en;
        logic              tab_sel;
        logic [TAB_AW-1:0] addr;
    } rom_req_t;

    typedef logic signed [TAB_W-1:0] act_tab_t [ACT_TABLE_DEPTH+1];

    // restoring division, elaboration only
    function automatic logic [63:0] nma_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-a), a in Q32.32, result Q0.32
    function automatic logic [63:0] nma_exp_neg(input logic [63:0] a);
        logic [63:0]        f;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        int                 n;
        f    = {32'd0, a[31:0]};
        n    = int'(a[63:32]);
        term = Q32_ONE;
        sum  = signed'(Q32_ONE);
        for (int k = 1; k <= 14; k++) begin
            term = nma_udiv((term * f) >> 32, 64'(k));
            if ((k & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        r = (sum < 0) ? 64'd0 : unsigned'(sum);
        for (int j = 0; j < n; j++) begin
            r = (r * INV_E_Q32 + (64'd1 << 31)) >> 32;
        end
        return r;
    endfunction

    function automatic logic signed [TAB_W-1:0] nma_act_entry(input int idx, input logic is_tanh);
        int          num;
        logic [63:0] mag;
        logic [63:0] a;
        logic [63:0] e1;
        logic [63:0] e2;
        logic [63:0] den1;
        logic [63:0] den2;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] th;
        logic [63:0] sg;
        logic [63:0] v;
        num  = 16 * idx - 8 * ACT_TABLE_DEPTH;
        mag  = 64'((num < 0) ? -num : num);
        a    = (mag << 32) / ACT_DEPTH_U64;
        e1   = nma_exp_neg(a);
        e2   = nma_exp_neg(a << 1);
        den1 = Q32_ONE + e1;
        den2 = Q32_ONE + e2;
        hi   = (64'd1 << 48) + (den1 >> 1);
        lo   = (e1 << 16) + (den1 >> 1);
        th   = nma_udiv(((Q32_ONE - e2) << 16) + (den2 >> 1), den2);
        sg   = nma_udiv((num < 0) ? lo : hi, den1);
        if (is_tanh) begin
            v = (num < 0) ? (64'd0 - th) : th;
        end else begin
            v = sg;
        end
        return v[TAB_W-1:0];
    endfunction

    function automatic act_tab_t nma_act_table(input logic is_tanh);
        act_tab_t t;
        for (int i = 0; i <= ACT_TABLE_DEPTH; i++) begin
            t[i] = nma_act_entry(i, is_tanh);
        end
        return t;
    endfunction

endpackage

@@ rtl/core/nma_act_rom.sv @@
module nma_act_rom
    import nma_pkg::*;
(
    input  logic                    aclk,
    input  rom_req_t                req,
    output logic signed [TAB_W-1:0] rd_data
);

    localparam act_tab_t SIG_TAB  = nma_act_table(1'b0);
    localparam act_tab_t TANH_TAB = nma_act_table(1'b1);

    logic signed [TAB_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= req.tab_sel ? TANH_TAB[req.addr] : SIG_TAB[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/neuron_mac_activation_unit.sv @@
// Channel   Ports                         Moves
// input     s_valid s_ready s_data        one (x_value, weight, last) transaction
// result    m_valid m_ready m_data        one activation_out/overflow per vector
// config    cfg_wr_en cfg_addr cfg_wdata  bias, activation_select, leak_slope
//
// Element without last: multiply on accept, then a saturating accumulate.
// Element with last: ST_BIAS, ST_ACT, then relu ST_OUT, leaky ST_LEAKY if z < 0,
// sigmoid/tanh ST_TIDX, ST_TRD1, ST_TRD2, ST_TFIN, or ST_EDGE at the table edges;
// all multiplies share one 32x32 multiplier and the tables have one read port.
// Synchronous active-low reset; the tables are constants, no fill after reset.
// A result waits in the output register; a new result stalls only while it is held.
module neuron_mac_activation_unit
    import nma_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [DATA_W-1:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic signed [DATA_W-1:0] bias_reg;
    act_sel_t                 act_sel_reg;
    logic [SLOPE_W-1:0]       slope_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic                     sat_reg;
    logic                     last_reg;
    logic signed [63:0]       prod_reg;
    logic signed [DATA_W-1:0] z_reg;
    logic                     ovf_reg;
    logic [TAB_AW-1:0]        idx_reg;
    logic [TAB_FRAC_W-1:0]    fr_reg;
    logic signed [TAB_W-1:0]  t0_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic                     prod_load;
    logic signed [63:0]       mul_p;
    rom_req_t                 rom_req;
    logic signed [TAB_W-1:0]  rom_data;
    logic                     res_load;
    logic signed [DATA_W-1:0] res_val;
    logic                     out_load;

    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;
    logic                     acc_ovf;
    logic signed [ACC_W:0]    z_sum;
    logic                     z_hi, z_lo;
    logic signed [DATA_W:0]   u_val;
    logic                     u_low, u_high;
    logic signed [TAB_W:0]    t_diff;
    logic [TAB_AW-1:0]        p_idx;

    nma_act_rom u_rom (
        .aclk    (aclk),
        .req     (rom_req),
        .rd_data (rom_data)
    );

    assign mul_p = mul_a * mul_b;

    assign acc_sum = $signed({acc_reg[ACC_W-1], acc_reg})
                   + $signed({prod_reg[63], prod_reg[63:Q_FRAC_W]});
    assign acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
    assign acc_sat = acc_ovf ? {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}}
                             : acc_sum[ACC_W-1:0];

    assign z_sum = $signed({acc_reg[ACC_W-1], acc_reg})
                 + $signed({{(ACC_W+1-DATA_W){bias_reg[DATA_W-1]}}, bias_reg});
    assign z_hi  = !z_sum[ACC_W] && (z_sum[ACC_W-1:DATA_W-1] != '0);
    assign z_lo  = z_sum[ACC_W] && (z_sum[ACC_W-1:DATA_W-1] != '1);

    assign u_val  = $signed({z_reg[DATA_W-1], z_reg}) + $signed(U_OFFSET);
    assign u_low  = u_val[DATA_W];
    assign u_high = !u_val[DATA_W] && (u_val[DATA_W-1:TAB_FRAC_W] != '0);

    assign t_diff = $signed({rom_data[TAB_W-1], rom_data}) - $signed({t0_reg[TAB_W-1], t0_reg});
    assign p_idx  = prod_reg[TAB_FRAC_W +: TAB_AW];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:  state_next = last_reg ? ST_BIAS : ST_IDLE;
            ST_BIAS: state_next = ST_ACT;
            ST_ACT: begin
                unique case (act_sel_reg) inside
                    ACT_SIGMOID, ACT_TANH: state_next = (u_low || u_high) ? ST_EDGE : ST_TIDX;
                    ACT_RELU:              state_next = ST_OUT;
                    default:               state_next = z_reg[DATA_W-1] ? ST_LEAKY : ST_OUT;
                endcase
            end
            ST_LEAKY: state_next = ST_OUT;
            ST_EDGE:  state_next = ST_OUT;
            ST_TIDX:  state_next = ST_TRD1;
            ST_TRD1:  state_next = ST_TRD2;
            ST_TRD2:  state_next = ST_TFIN;
            ST_TFIN:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        prod_load       = 1'b0;
        rom_req.rd_en   = 1'b0;
        rom_req.tab_sel = act_sel_reg == ACT_TANH;
        rom_req.addr    = '0;
        res_load        = 1'b0;
        res_val         = z_reg;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                mul_a     = s_data.x_value;
                mul_b     = s_data.weight;
                prod_load = s_valid;
            end
            ST_ACT: begin
                unique case (act_sel_reg) inside
                    ACT_SIGMOID, ACT_TANH: begin
                        mul_a         = $signed({{(DATA_W-TAB_FRAC_W){1'b0}},
                                                 u_val[TAB_FRAC_W-1:0]});
                        mul_b         = DATA_W'(ACT_TABLE_DEPTH);
                        prod_load     = 1'b1;
                        rom_req.rd_en = u_low || u_high;
                        rom_req.addr  = u_low ? '0 : TAB_AW'(ACT_TABLE_DEPTH);
                    end
                    ACT_RELU: begin
                        res_load = 1'b1;
                        res_val  = z_reg[DATA_W-1] ? '0 : z_reg;
                    end
                    default: begin
                        mul_a     = z_reg;
                        mul_b     = $signed({{(DATA_W-SLOPE_W){1'b0}}, slope_reg});
                        prod_load = 1'b1;
                        res_load  = 1'b1;
                        res_val   = z_reg;
                    end
                endcase
            end
            ST_LEAKY: begin
                res_load = 1'b1;
                res_val  = prod_reg[Q_FRAC_W +: DATA_W];
            end
            ST_EDGE: begin
                res_load = 1'b1;
                res_val  = DATA_W'(rom_data);
            end
            ST_TIDX: begin
                rom_req.rd_en = 1'b1;
                rom_req.addr  = p_idx;
            end
            ST_TRD1: begin
                rom_req.rd_en = 1'b1;
                rom_req.addr  = idx_reg + TAB_AW'(1);
            end
            ST_TRD2: begin
                mul_a     = DATA_W'(t_diff);
                mul_b     = $signed({{(DATA_W-TAB_FRAC_W){1'b0}}, fr_reg});
                prod_load = 1'b1;
            end
            ST_TFIN: begin
                res_load = 1'b1;
                res_val  = DATA_W'(t0_reg) + prod_reg[TAB_FRAC_W +: DATA_W];
            end
            ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            bias_reg    <= '0;
            act_sel_reg <= ACT_SIGMOID;
            slope_reg   <= SLOPE_W'(655);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_ACC) begin
                acc_reg <= acc_sat;
                sat_reg <= sat_reg | acc_ovf;
            end else if (state_reg == ST_BIAS) begin
                acc_reg <= '0;
                sat_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BIAS:       bias_reg    <= cfg_wdata;
                    CFG_ACT_SEL:    act_sel_reg <= act_sel_t'(cfg_wdata[1:0]);
                    CFG_LEAK_SLOPE: slope_reg   <= cfg_wdata[SLOPE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_load) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_IDLE && s_valid) begin
            last_reg <= s_data.last;
        end
        if (state_reg == ST_BIAS) begin
            ovf_reg <= sat_reg | z_hi | z_lo;
            if (z_hi) begin
                z_reg <= {1'b0, {(DATA_W-1){1'b1}}};
            end else if (z_lo) begin
                z_reg <= {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                z_reg <= z_sum[DATA_W-1:0];
            end
        end
        if (state_reg == ST_TIDX) begin
            idx_reg <= p_idx;
            fr_reg  <= prod_reg[TAB_FRAC_W-1:0];
        end
        if (state_reg == ST_TRD1) begin
            t0_reg <= rom_data;
        end
        if (res_load) begin
            res_reg <= res_val;
        end
        if (out_load) begin
            m_data_reg.activation_out <= res_reg;
            m_data_reg.overflow       <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
